>>> hdl/touch_average_clamp_scale_core_macros.svh
// Assertion macros shared by the touch averaging block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef TOUCH_AVERAGE_CLAMP_SCALE_CORE_MACROS_SVH
`define TOUCH_AVERAGE_CLAMP_SCALE_CORE_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define TACS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define TACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

>>> hdl/tacs_pkg.sv
// Package for the touch averaging block: widths, constants, state and config types.
// Used by tacs_cfg, tacs_div and touch_average_clamp_scale_core.
package tacs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 23;
    localparam int CNT_W       = 8;
    localparam int POS_W       = 9;
    localparam int DIV_W       = 25;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_SAMPLES = 128;

    // Screen spans in pixels.
    localparam logic [POS_W-1:0] SPAN_NARROW = 9'd240;
    localparam logic [POS_W-1:0] SPAN_WIDE   = 9'd320;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y        = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_SCL_START,
        ST_SCL_WAIT,
        ST_EMIT
    } t_state;

    // Configuration as seen by the sequencer; count is already held to its range.
    typedef struct packed {
        logic [1:0]          rotation;
        logic [CNT_W-1:0]    count;
        logic [SAMPLE_W-1:0] min_x;
        logic [SAMPLE_W-1:0] max_x;
        logic [SAMPLE_W-1:0] min_y;
        logic [SAMPLE_W-1:0] max_y;
    } t_cfg;

endpackage

>>> hdl/tacs_cfg.sv
// Configuration registers of the touch averaging block and the sample count clamp.
// Depends on tacs_pkg.
module tacs_cfg
    import tacs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [SAMPLE_W-1:0]  i_data,
    output t_cfg                 o_cfg
);

    logic [1:0]          r_rotation;
    logic [CNT_W-1:0]    r_sample_count;
    logic [SAMPLE_W-1:0] r_min_x;
    logic [SAMPLE_W-1:0] r_max_x;
    logic [SAMPLE_W-1:0] r_min_y;
    logic [SAMPLE_W-1:0] r_max_y;
    logic [CNT_W-1:0]    eff_count;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation     <= 2'd1;
            r_sample_count <= 8'd1;
            r_min_x        <= 16'd0;
            r_max_x        <= 16'hFFFF;
            r_min_y        <= 16'd0;
            r_max_y        <= 16'hFFFF;
        end else if (i_wr) begin
            case (i_index)
                CFG_ROTATION:     r_rotation     <= i_data[1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_data[CNT_W-1:0];
                CFG_MIN_X:        r_min_x        <= i_data;
                CFG_MAX_X:        r_max_x        <= i_data;
                CFG_MIN_Y:        r_min_y        <= i_data;
                CFG_MAX_Y:        r_max_y        <= i_data;
                default: begin
                end
            endcase
        end
    end

    // A count of zero acts as one, and one above the limit acts as the limit.
    always_comb begin
        eff_count = r_sample_count;
        if (eff_count == '0) begin
            eff_count = CNT_W'(1);
        end
        if (eff_count > CNT_W'(MAX_SAMPLES)) begin
            eff_count = CNT_W'(MAX_SAMPLES);
        end
    end

    assign o_cfg = '{rotation: r_rotation, count: eff_count,
                     min_x: r_min_x, max_x: r_max_x,
                     min_y: r_min_y, max_y: r_max_y};

endmodule

>>> hdl/tacs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tacs_pkg for the dividend width.
module tacs_div
    import tacs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [SAMPLE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SAMPLE_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0]  r_den;
    logic [DIV_W-1:0]     r_q;
    logic [SAMPLE_W:0]    trial;
    logic                 q_bit;
    logic [SAMPLE_W-1:0]  n_rem;

    // One trial subtraction: shift in the next dividend bit and compare.
    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        q_bit = (trial >= {1'b0, r_den});
        if (q_bit) begin
            n_rem = SAMPLE_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = trial[SAMPLE_W-1:0];
        end
    end

    // Control: busy while the DIV_W quotient bits are worked out, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in from the right as the dividend leaves.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[DIV_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> hdl/touch_average_clamp_scale_core.sv
// Touch sample averaging with clamp to a calibration window and scaling to pixels.
// Top level; depends on tacs_pkg, tacs_cfg, tacs_div and the assertion macro header.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one request per touch sample: the pen
//   state and the readings of conversion channels 0xD0 and 0x90. Output channel
//   (o_valid / i_ready) returns touch_valid, pos_x and pos_y. The config channel
//   (i_cfg_valid / o_cfg_ready) writes a register by index and is always ready.
//   A pen-down sample that does not complete the count gives no result, and the
//   sequencer stays idle. A pen-up sample gives an invalid result via ST_EMIT.
//   The sample that completes the count starts four divisions on one shared
//   restoring divider, one after another, and the divider makes one quotient
//   bit per cycle; the result is emitted after the last of the divisions.
//   o_ready is high only while the sequencer is idle.
//   A finished result sits in the output register while the next sample is
//   taken; if the receiver still stalls when another result is ready, the
//   sequencer holds it and drops o_ready until the output register frees.
//   Reset clears the sums, the count of samples taken and the output valid flag,
//   and restores the default configuration.
`include "touch_average_clamp_scale_core_macros.svh"

module touch_average_clamp_scale_core
    import tacs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_pen_down,
    input  logic [SAMPLE_W-1:0]  i_chan_d0_sample,
    input  logic [SAMPLE_W-1:0]  i_chan_90_sample,
    // Result output channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_touch_valid,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    t_state              r_state;
    t_state              n_state;
    t_cfg                cfg;

    logic [ACC_W-1:0]    r_acc_x;
    logic [ACC_W-1:0]    r_acc_y;
    logic [CNT_W-1:0]    r_taken;
    logic                r_axis;
    logic [SAMPLE_W-1:0] r_diff;
    logic                r_zero;
    logic                r_res_valid;
    logic [POS_W-1:0]    r_res_x;
    logic [POS_W-1:0]    r_res_y;
    logic                r_out_valid;
    logic                r_out_touch_valid;
    logic [POS_W-1:0]    r_out_pos_x;
    logic [POS_W-1:0]    r_out_pos_y;

    logic                in_acc;
    logic                odd;
    logic [SAMPLE_W-1:0] smp_x;
    logic [SAMPLE_W-1:0] smp_y;
    logic [ACC_W-1:0]    sum_x;
    logic [ACC_W-1:0]    sum_y;
    logic [CNT_W-1:0]    taken_inc;
    logic                count_hit;
    logic [ACC_W-1:0]    sel_acc;
    logic [SAMPLE_W-1:0] sel_lo;
    logic [SAMPLE_W-1:0] sel_hi;
    logic [POS_W-1:0]    span;
    logic [DIV_W-1:0]    lo_ext;
    logic [DIV_W-1:0]    hi_ext;
    logic [DIV_W-1:0]    clamped;
    logic [DIV_W-1:0]    prod;
    logic [POS_W-1:0]    scaled;
    logic                out_free;
    logic                emit_load;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [SAMPLE_W-1:0] div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    assign o_cfg_ready = 1'b1;

    tacs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tacs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Channel routing and accumulation of the incoming sample.
    assign in_acc    = i_valid && o_ready;
    assign odd       = cfg.rotation[0];
    assign smp_x     = odd ? i_chan_90_sample : i_chan_d0_sample;
    assign smp_y     = odd ? i_chan_d0_sample : i_chan_90_sample;
    assign sum_x     = r_acc_x + ACC_W'(smp_x);
    assign sum_y     = r_acc_y + ACC_W'(smp_y);
    assign taken_inc = r_taken + CNT_W'(1);
    assign count_hit = (taken_inc >= cfg.count);

    // Operands of the axis now in work.
    assign sel_acc = r_axis ? r_acc_y : r_acc_x;
    assign sel_lo  = r_axis ? cfg.min_y : cfg.min_x;
    assign sel_hi  = r_axis ? cfg.max_y : cfg.max_x;
    assign span    = (odd ^ r_axis) ? SPAN_WIDE : SPAN_NARROW;
    assign lo_ext  = DIV_W'(sel_lo);
    assign hi_ext  = DIV_W'(sel_hi);
    assign prod    = DIV_W'(r_diff) * DIV_W'(span);
    assign scaled  = r_zero ? '0 : div_quot[POS_W-1:0];

    // Clamp the average: raise to the lower bound, then lower to the upper bound.
    always_comb begin
        clamped = div_quot;
        if (clamped < lo_ext) begin
            clamped = lo_ext;
        end
        if (clamped > hi_ext) begin
            clamped = hi_ext;
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign emit_load = (r_state == ST_EMIT) && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_pen_down) begin
                        n_state = ST_EMIT;
                    end else if (count_hit) begin
                        n_state = ST_AVG_START;
                    end
                end
            end
            ST_AVG_START: n_state = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (div_done) begin
                    n_state = ST_SCL_START;
                end
            end
            ST_SCL_START: n_state = ST_SCL_WAIT;
            ST_SCL_WAIT: begin
                if (div_done) begin
                    n_state = r_axis ? ST_EMIT : ST_AVG_START;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider operand selection.
    always_comb begin
        o_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod;
        div_divisor  = sel_hi - sel_lo;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_AVG_START: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(sel_acc);
                div_divisor  = SAMPLE_W'(cfg.count);
            end
            ST_SCL_START: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_taken     <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_acc) begin
                r_axis <= 1'b0;
                if (!i_pen_down) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_taken <= '0;
                end else begin
                    r_acc_x <= sum_x;
                    r_acc_y <= sum_y;
                    r_taken <= taken_inc;
                end
            end
            if (r_state == ST_SCL_WAIT && div_done) begin
                if (r_axis) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_taken <= '0;
                end
                r_axis <= 1'b1;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: axis intermediates, staged result, output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc && !i_pen_down) begin
            r_res_valid <= 1'b0;
            r_res_x     <= '0;
            r_res_y     <= '0;
        end
        if (r_state == ST_AVG_WAIT && div_done) begin
            r_diff <= SAMPLE_W'(clamped - lo_ext);
            r_zero <= (sel_hi <= sel_lo);
        end
        if (r_state == ST_SCL_WAIT && div_done) begin
            if (r_axis) begin
                r_res_y     <= scaled;
                r_res_valid <= 1'b1;
            end else begin
                r_res_x <= scaled;
            end
        end
        if (emit_load) begin
            r_out_touch_valid <= r_res_valid;
            r_out_pos_x       <= r_res_x;
            r_out_pos_y       <= r_res_y;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_touch_valid = r_out_touch_valid;
    assign o_pos_x       = r_out_pos_x;
    assign o_pos_y       = r_out_pos_y;

    // An invalid result carries zero coordinates.
    `TACS_ASSERT_IMPL(a_invalid_zero, r_out_valid && !r_out_touch_valid,
                      r_out_pos_x == '0 && r_out_pos_y == '0)
    // Coordinates never exceed the wide screen span.
    `TACS_ASSERT_IMPL(a_pos_range, r_out_valid,
                      r_out_pos_x <= SPAN_WIDE && r_out_pos_y <= SPAN_WIDE)
    // With no sample taken, both sums are clear.
    `TACS_ASSERT_IMPL(a_sums_clear, r_taken == '0, r_acc_x == '0 && r_acc_y == '0)
    // A pen-up request goes straight to result delivery.
    `TACS_ASSERT_NEXT(a_pen_up_emit, in_acc && !i_pen_down, r_state == ST_EMIT)

endmodule

>>> tb/sv/touch_report_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the touch averaging block: watches the sample, result and register channels,
// predicts every touch report and compares it field by field. Depends on tacs_pkg only.
module touch_report_checker
    import tacs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample_valid,
    input  logic                 i_sample_ready,
    input  logic                 i_pen_down,
    input  logic [SAMPLE_W-1:0]  i_chan_d0_sample,
    input  logic [SAMPLE_W-1:0]  i_chan_90_sample,
    input  logic                 i_result_valid,
    input  logic                 i_result_ready,
    input  logic                 i_touch_valid,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending,
    output int unsigned          o_results_seen,
    output int unsigned          o_full_readings
);

    typedef struct packed {
        logic             touch_valid;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_touch_report;

    // Reports predicted but not yet returned by the block, oldest first.
    t_touch_report expected_reports[$];

    // Local copy of the register file.
    logic [1:0]          rotation_q;
    logic [CNT_W-1:0]    count_q;
    logic [SAMPLE_W-1:0] min_x_q;
    logic [SAMPLE_W-1:0] max_x_q;
    logic [SAMPLE_W-1:0] min_y_q;
    logic [SAMPLE_W-1:0] max_y_q;

    // Local copy of the running sums.
    logic [ACC_W-1:0]    acc_x_q;
    logic [ACC_W-1:0]    acc_y_q;
    logic [CNT_W-1:0]    taken_q;

    // The sample count is held to 1 .. MAX_SAMPLES.
    function automatic int unsigned held_count(input logic [CNT_W-1:0] raw);
        int unsigned n;
        n = 32'(raw);
        if (n < 1) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        return n;
    endfunction

    // Average, clamp to the window, then map the window linearly onto the span.
    function automatic logic [POS_W-1:0] scale_to_pixels(input logic [ACC_W-1:0] acc,
                                                         input int unsigned n,
                                                         input logic [SAMPLE_W-1:0] lo,
                                                         input logic [SAMPLE_W-1:0] hi,
                                                         input int unsigned span);
        int unsigned raw;
        int unsigned lo_u;
        int unsigned hi_u;
        int unsigned scaled;
        lo_u = 32'(lo);
        hi_u = 32'(hi);
        raw  = 32'(acc);
        raw  = raw / n;
        if (raw < lo_u) raw = lo_u;
        if (raw > hi_u) raw = hi_u;
        if (hi_u <= lo_u) begin
            scaled = 0;
        end else begin
            scaled = ((raw - lo_u) * span) / (hi_u - lo_u);
        end
        return scaled[POS_W-1:0];
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SAMPLE_W-1:0] data);
        case (idx)
            CFG_ROTATION:     rotation_q = data[1:0];
            CFG_SAMPLE_COUNT: count_q    = data[CNT_W-1:0];
            CFG_MIN_X:        min_x_q    = data;
            CFG_MAX_X:        max_x_q    = data;
            CFG_MIN_Y:        min_y_q    = data;
            CFG_MAX_Y:        max_y_q    = data;
            default: ;
        endcase
    endtask

    // Fold one accepted sample into the sums and queue the report it causes, if any.
    task automatic predict_touch_report(input logic pen,
                                        input logic [SAMPLE_W-1:0] d0,
                                        input logic [SAMPLE_W-1:0] c90);
        logic          odd;
        int unsigned   n;
        t_touch_report rep;
        odd = rotation_q[0];
        rep = '0;
        if (!pen) begin
            // A release always reports an invalid touch and drops the partial sums.
            acc_x_q = '0;
            acc_y_q = '0;
            taken_q = '0;
            expected_reports.push_back(rep);
        end else begin
            // Odd rotations swap the channels, per sample.
            acc_x_q = acc_x_q + ACC_W'(odd ? c90 : d0);
            acc_y_q = acc_y_q + ACC_W'(odd ? d0 : c90);
            taken_q = taken_q + CNT_W'(1);
            n = held_count(count_q);
            if (32'(taken_q) >= n) begin
                rep.touch_valid = 1'b1;
                rep.pos_x = scale_to_pixels(acc_x_q, n, min_x_q, max_x_q,
                                            32'(odd ? SPAN_WIDE : SPAN_NARROW));
                rep.pos_y = scale_to_pixels(acc_y_q, n, min_y_q, max_y_q,
                                            32'(odd ? SPAN_NARROW : SPAN_WIDE));
                acc_x_q = '0;
                acc_y_q = '0;
                taken_q = '0;
                expected_reports.push_back(rep);
            end
        end
    endtask

    // Compare one returned report against the oldest prediction.
    task automatic check_result();
        t_touch_report want;
        o_results_seen++;
        if (expected_reports.size() == 0) begin
            o_fail_count++;
            $error("unexpected report: touch_valid %0d, pos_x %0d, pos_y %0d",
                   i_touch_valid, i_pos_x, i_pos_y);
        end else begin
            want = expected_reports.pop_front();
            if (want.touch_valid) o_full_readings++;
            if (i_touch_valid !== want.touch_valid) begin
                o_fail_count++;
                $error("touch_valid: expected %0d, got %0d", want.touch_valid, i_touch_valid);
            end
            if (i_pos_x !== want.pos_x) begin
                o_fail_count++;
                $error("pos_x: expected %0d, got %0d", want.pos_x, i_pos_x);
            end
            if (i_pos_y !== want.pos_y) begin
                o_fail_count++;
                $error("pos_y: expected %0d, got %0d", want.pos_y, i_pos_y);
            end
        end
    endtask

    // All three channels are sampled on the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rotation_q      = 2'd1;
            count_q         = 8'd1;
            min_x_q         = 16'd0;
            max_x_q         = 16'hFFFF;
            min_y_q         = 16'd0;
            max_y_q         = 16'hFFFF;
            acc_x_q         = '0;
            acc_y_q         = '0;
            taken_q         = '0;
            o_fail_count    = 0;
            o_results_seen  = 0;
            o_full_readings = 0;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (i_result_valid && i_result_ready) begin
                check_result();
            end
            if (i_sample_valid && i_sample_ready) begin
                predict_touch_report(i_pen_down, i_chan_d0_sample, i_chan_90_sample);
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

>>> tb/sv/touch_average_clamp_scale_core_test.sv
`timescale 1ns / 100ps
// Top of the touch averaging testbench: clock, reset, sample and register stimulus, result sink.
// Depends on tacs_pkg, the block touch_average_clamp_scale_core and touch_report_checker.
module touch_average_clamp_scale_core_test;
    import tacs_pkg::*;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASES        = 10;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 256;
    localparam int CYCLE_LIMIT   = 1000000;

    // Indexes past the last register; writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_pen_down;
    logic [SAMPLE_W-1:0]  i_chan_d0_sample;
    logic [SAMPLE_W-1:0]  i_chan_90_sample;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_touch_valid;
    logic [POS_W-1:0]     o_pos_x;
    logic [POS_W-1:0]     o_pos_y;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SAMPLE_W-1:0]  i_cfg_data;

    int unsigned          fail_count;
    int unsigned          outstanding;
    int unsigned          results_seen;
    int unsigned          full_readings;

    int unsigned          cycle_count;
    int                   samples_sent;
    int                   settings_used;
    int                   calm_sender;
    int                   calm_sink;
    logic [CNT_W-1:0]     count_setting;

    touch_average_clamp_scale_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pen_down       (i_pen_down),
        .i_chan_d0_sample (i_chan_d0_sample),
        .i_chan_90_sample (i_chan_90_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_touch_valid    (o_touch_valid),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    touch_report_checker report_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_valid),
        .i_sample_ready   (o_ready),
        .i_pen_down       (i_pen_down),
        .i_chan_d0_sample (i_chan_d0_sample),
        .i_chan_90_sample (i_chan_90_sample),
        .i_result_valid   (o_valid),
        .i_result_ready   (i_ready),
        .i_touch_valid    (o_touch_valid),
        .i_pos_x          (o_pos_x),
        .i_pos_y          (o_pos_y),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (outstanding),
        .o_results_seen   (results_seen),
        .o_full_readings  (full_readings)
    );

    // Free-running 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d reports outstanding", cycle_count,
                 outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Result sink: random back-pressure per report, with occasional stall-free runs.
    initial begin : result_sink
        int stall;
        i_ready   = 1'b0;
        calm_sink = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (calm_sink > 0) begin
                stall = 0;
                calm_sink--;
            end else begin
                if ($urandom_range(0, 15) == 0) calm_sink = $urandom_range(10, 60);
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Offer one sample after a random gap and hold it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_sample(input logic pen, input logic [SAMPLE_W-1:0] d0,
                               input logic [SAMPLE_W-1:0] c90);
        int gap;
        if (calm_sender > 0) begin
            gap = 0;
            calm_sender--;
        end else begin
            if ($urandom_range(0, 15) == 0) calm_sender = $urandom_range(10, 60);
            gap = $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_pen_down       <= pen;
        i_chan_d0_sample <= d0;
        i_chan_90_sample <= c90;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // Stop offering samples, wait for every report, then let any partial work finish.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write request; only issued while the block is settled.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SAMPLE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_SAMPLE_COUNT) count_setting = data[CNT_W-1:0];
    endtask

    // Readings cluster around the touch point, with rail values and wild outliers mixed in.
    function automatic logic [SAMPLE_W-1:0] jittered_sample(input logic [SAMPLE_W-1:0] center);
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       v = 0;
            1:       v = 65535;
            2, 3:    v = $urandom_range(0, 65535);
            default: begin
                v = $urandom_range(0, 2047);
                v = v - 1024 + int'(center);
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    // Calibration window: mostly sane, sometimes empty, inverted or pinned to a rail.
    task automatic pick_window(output logic [SAMPLE_W-1:0] lo, output logic [SAMPLE_W-1:0] hi);
        int sel;
        int a;
        int b;
        sel = $urandom_range(0, 9);
        a   = $urandom_range(0, 65535);
        b   = $urandom_range(0, 65535);
        case (sel)
            0, 1: begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            2, 3, 4: begin
                lo = 16'((a < b) ? a : b);
                hi = 16'((a < b) ? b : a);
            end
            5, 6: begin
                a  = $urandom_range(0, 60000);
                lo = 16'(a);
                hi = 16'(a + $urandom_range(1, 4000));
            end
            7: begin
                lo = 16'((a < b) ? b : a);
                hi = 16'((a < b) ? a : b);
            end
            8: begin
                lo = 16'(a);
                hi = 16'(a);
            end
            default: begin
                lo = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                hi = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            end
        endcase
    endtask

    // New settings for a random phase; the first few pin the count to its extremes.
    task automatic randomize_settings(input int phase);
        logic [CNT_W-1:0]    cnt;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        int                  sel;
        sel = $urandom_range(0, 9);
        case (phase)
            0:       cnt = 8'd128;
            1:       cnt = 8'd255;
            2:       cnt = 8'd0;
            3:       cnt = 8'd1;
            default: begin
                if (sel < 6)      cnt = 8'($urandom_range(1, 8));
                else if (sel < 8) cnt = 8'($urandom_range(9, 127));
                else if (sel < 9) cnt = 8'($urandom_range(129, 255));
                else              cnt = 8'd0;
            end
        endcase
        // Upper data bits beyond each register's width are random.
        write_register(CFG_ROTATION, {14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3))});
        write_register(CFG_SAMPLE_COUNT, {8'($urandom_range(0, 255)), cnt});
        pick_window(lo, hi);
        if (phase == 0) begin
            lo = 16'd0;
            hi = 16'hFFFF;
        end
        write_register(CFG_MIN_X, lo);
        write_register(CFG_MAX_X, hi);
        pick_window(lo, hi);
        write_register(CFG_MIN_Y, lo);
        write_register(CFG_MAX_Y, hi);
        settings_used++;
    endtask

    // One touch gesture: full readings, an early release, or loose noise.
    task automatic run_touch();
        int                  kind;
        int                  len;
        int                  held;
        logic [SAMPLE_W-1:0] cx;
        logic [SAMPLE_W-1:0] cy;
        held = int'(count_setting);
        if (held < 1) held = 1;
        if (held > MAX_SAMPLES) held = MAX_SAMPLES;
        kind = $urandom_range(0, 9);
        cx   = 16'($urandom_range(0, 65535));
        cy   = 16'($urandom_range(0, 65535));
        if (kind < 6) begin
            len = (held > 16) ? held : held * $urandom_range(1, 3);
            repeat (len) send_sample(1'b1, jittered_sample(cx), jittered_sample(cy));
            if ($urandom_range(0, 1)) begin
                send_sample(1'b0, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
            end
        end else if (kind < 8) begin
            len = $urandom_range(0, held - 1);
            repeat (len) send_sample(1'b1, jittered_sample(cx), jittered_sample(cy));
            send_sample(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Main sequence: reset, directed cases, random phases, drain and verdict.
    initial begin : stimulus
        int phase;
        int budget;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_pen_down       = 1'b0;
        i_chan_d0_sample = '0;
        i_chan_90_sample = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_ROTATION;
        i_cfg_data       = '0;
        samples_sent     = 0;
        settings_used    = 1;
        calm_sender      = 0;
        count_setting    = 8'd1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset: rotation 1, one sample per reading, full windows.
        // A release before any sample still reports an invalid touch.
        send_sample(1'b0, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'hFFFF, 16'hFFFF);
        send_sample(1'b1, 16'hFFFF, 16'h0000);
        send_sample(1'b1, 16'h5555, 16'hAAAA);
        settle_block();

        // Two-sample readings with values beyond both ends of the windows.
        write_register(CFG_ROTATION, 16'd0);
        write_register(CFG_SAMPLE_COUNT, 16'd2);
        write_register(CFG_MIN_X, 16'd1000);
        write_register(CFG_MAX_X, 16'd60000);
        write_register(CFG_MIN_Y, 16'd100);
        write_register(CFG_MAX_Y, 16'd65000);
        settings_used++;
        send_sample(1'b1, 16'd500, 16'd64000);
        send_sample(1'b1, 16'd700, 16'd65535);
        send_sample(1'b1, 16'd30000, 16'd30000);
        send_sample(1'b1, 16'hAAAA, 16'h5555);
        send_sample(1'b1, 16'd1234, 16'd4321);
        send_sample(1'b0, 16'hFFFF, 16'hFFFF);
        settle_block();

        // Unused indexes, a zero count, an inverted x window and an empty y window.
        write_register(CFG_SPARE_LO, 16'hFFFF);
        write_register(CFG_SPARE_HI, 16'hFFFF);
        write_register(CFG_SAMPLE_COUNT, 16'd0);
        write_register(CFG_MIN_X, 16'd5000);
        write_register(CFG_MAX_X, 16'd4000);
        write_register(CFG_MIN_Y, 16'd3000);
        write_register(CFG_MAX_Y, 16'd3000);
        write_register(CFG_ROTATION, 16'd3);
        settings_used++;
        send_sample(1'b1, 16'd4500, 16'd3000);
        send_sample(1'b1, 16'hFFFF, 16'h0000);
        settle_block();

        // Start a four-sample reading, then lower the count and flip rotation halfway.
        write_register(CFG_SAMPLE_COUNT, 16'd4);
        write_register(CFG_MIN_X, 16'd0);
        write_register(CFG_MAX_X, 16'hFFFF);
        write_register(CFG_MIN_Y, 16'd0);
        write_register(CFG_MAX_Y, 16'hFFFF);
        write_register(CFG_ROTATION, 16'd2);
        settings_used++;
        send_sample(1'b1, 16'hF000, 16'h1000);
        send_sample(1'b1, 16'hE000, 16'h2000);
        send_sample(1'b1, 16'hFFFF, 16'h0800);
        settle_block();
        write_register(CFG_SAMPLE_COUNT, 16'd2);
        write_register(CFG_ROTATION, 16'd1);
        settings_used++;
        send_sample(1'b1, 16'hFFFF, 16'h8000);
        settle_block();

        // Random phases, each under fresh settings.
        for (phase = 0; phase < PHASES; phase++) begin
            randomize_settings(phase);
            budget = samples_sent + RANDOM_ITEMS / PHASES;
            while (samples_sent < budget) run_touch();
            settle_block();
        end

        $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
        $display("Checked %0d reports, %0d of them completed readings.", results_seen,
                 full_readings);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
